// File: rtl/dtoi_pkg.sv
// Shared types, constants and helpers for the decimal text to integer converter.
package dtoi_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int STOP_BITS   = 16;
    localparam int OFF_EXT     = (OFFSET_BITS > STOP_BITS) ? OFFSET_BITS : STOP_BITS;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    localparam logic [1:0] FMT_U64 = 2'd0;
    localparam logic [1:0] FMT_S64 = 2'd1;
    localparam logic [1:0] FMT_U32 = 2'd2;
    localparam logic [1:0] FMT_S32 = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Limit divided by ten and its remainder, per format and sign.
    localparam logic [63:0] U64_Q     = 64'd1844674407370955161;
    localparam logic [3:0]  U64_R     = 4'd5;
    localparam logic [63:0] S64_Q     = 64'd922337203685477580;
    localparam logic [3:0]  S64_POS_R = 4'd7;
    localparam logic [3:0]  S64_NEG_R = 4'd8;
    localparam logic [63:0] U32_Q     = 64'd429496729;
    localparam logic [3:0]  U32_R     = 4'd5;
    localparam logic [63:0] S32_Q     = 64'd214748364;
    localparam logic [3:0]  S32_POS_R = 4'd7;
    localparam logic [3:0]  S32_NEG_R = 4'd8;

    typedef struct packed {
        logic [63:0]          value;
        logic                 parse_ok;
        logic [STOP_BITS-1:0] stop_offset;
    } t_result;

    // Clamp the internal offset counter to the width of the result field.
    function automatic logic [STOP_BITS-1:0] clamp_offset(input logic [OFFSET_BITS-1:0] off);
        logic [OFF_EXT-1:0] ext;
        logic [OFF_EXT-1:0] top;
        ext = OFF_EXT'(off);
        top = OFF_EXT'({STOP_BITS{1'b1}});
        return (ext > top) ? {STOP_BITS{1'b1}} : ext[STOP_BITS-1:0];
    endfunction

endpackage

// File: rtl/dtoi_parse_core.sv
// Parse state and per-byte update logic of the decimal text to integer converter.
module dtoi_parse_core
    import dtoi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [1:0] i_format,
    output logic       o_emit,
    output t_result    o_result
);

    t_phase                 r_phase, n_phase;
    logic [63:0]            r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic                   r_err, n_err;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;

    logic                   is_signed;
    logic                   neg_eff;
    logic [63:0]            lim_q;
    logic [3:0]             lim_r;
    logic                   is_digit;
    logic [3:0]             digit;
    logic                   over;
    logic [63:0]            acc_next;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [63:0]            signed_val;
    logic [63:0]            final_val;

    assign is_signed = i_format[0];
    assign neg_eff   = is_signed & r_neg;

    always_comb begin
        case (i_format)
            FMT_U64: begin
                lim_q = U64_Q;
                lim_r = U64_R;
            end
            FMT_S64: begin
                lim_q = S64_Q;
                lim_r = neg_eff ? S64_NEG_R : S64_POS_R;
            end
            FMT_U32: begin
                lim_q = U32_Q;
                lim_r = U32_R;
            end
            default: begin
                lim_q = S32_Q;
                lim_r = neg_eff ? S32_NEG_R : S32_POS_R;
            end
        endcase
    end

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = 4'(i_byte - CH_ZERO);
    assign over     = (r_acc > lim_q) || ((r_acc == lim_q) && (digit > lim_r));
    // times ten as two shifts, plus the new digit
    assign acc_next = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0} + 64'(digit);
    assign off_inc  = (r_offset == {OFFSET_BITS{1'b1}}) ? r_offset
                                                         : r_offset + OFFSET_BITS'(1);

    assign signed_val = neg_eff ? (64'd0 - r_acc) : r_acc;
    always_comb begin
        final_val = signed_val;
        if (i_format[1]) begin
            final_val = {{32{is_signed & signed_val[31]}}, signed_val[31:0]};
        end
    end

    assign o_emit               = i_step && (i_byte == CH_NUL);
    assign o_result.value       = final_val;
    assign o_result.parse_ok    = (r_phase == PH_DIGITS) && !r_err;
    assign o_result.stop_offset = clamp_offset(r_offset);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_err    = r_err;
        n_offset = r_offset;
        if (i_step) begin
            if (i_byte == CH_NUL) begin
                n_phase  = PH_SKIP;
                n_acc    = '0;
                n_neg    = 1'b0;
                n_err    = 1'b0;
                n_offset = '0;
            end else begin
                case (r_phase)
                    PH_SKIP, PH_FIRST, PH_DIGITS: begin
                        if ((r_phase == PH_SKIP) && (i_byte <= CH_SPACE)) begin
                            n_offset = off_inc;
                        end else if ((r_phase == PH_SKIP) && (i_byte == CH_MINUS) && is_signed) begin
                            n_neg    = 1'b1;
                            n_phase  = PH_FIRST;
                            n_offset = off_inc;
                        end else if (!is_digit || over) begin
                            n_err   = 1'b1;
                            n_phase = PH_ERROR;
                        end else begin
                            n_acc    = acc_next;
                            n_phase  = PH_DIGITS;
                            n_offset = off_inc;
                        end
                    end
                    default: begin
                        // drop bytes until the terminator
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_err    <= 1'b0;
            r_offset <= '0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_err    <= n_err;
            r_offset <= n_offset;
        end
    end

endmodule

// File: rtl/decimal_text_to_integer.sv
// Top level of the decimal text to integer converter: input word register, parser, result register.
//
// Input channel: one text byte per word on i_char_byte, handshake i_in_valid / o_in_stall.
// A zero byte ends the string and produces exactly one result word; other bytes produce none.
// Output channel: o_value, o_parse_ok, o_stop_offset with handshake o_out_valid / i_out_stall.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the result format register
// (0 unsigned 64-bit, 1 signed 64-bit, 2 unsigned 32-bit, 3 signed 32-bit).
// A zero byte in the input register is parsed when it steps on, and its result word is
// loaded into the result register as o_out_valid rises. Throughput: one byte per cycle while
// the input is not stalled; the parser state update (times-ten add and limit compare) is
// combinational logic between the input register and the parser state registers.
// Reset (synchronous, active low) empties both registers, sets format 0 and
// returns the parser to skipping leading blanks.
// When the receiver stalls, the result register holds; non-zero bytes keep being
// parsed until a zero byte sits in the input register that cannot move on, and then
// o_in_stall rises until the result is taken.
module decimal_text_to_integer
    import dtoi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [63:0]          o_value,
    output logic                 o_parse_ok,
    output logic [STOP_BITS-1:0] o_stop_offset
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic [1:0] r_format;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;

    logic       step;
    logic       in_accept;
    logic       emit;
    t_result    core_result;

    // advance the held byte unless it would need a full, stalled result register
    assign step       = r_in_valid && !((r_in_byte == CH_NUL) && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    dtoi_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_format (r_format),
        .o_emit   (emit),
        .o_result (core_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_format    <= FMT_U64;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_format <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_char_byte;
        end
        if (emit) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_out.value;
    assign o_parse_ok    = r_out.parse_ok;
    assign o_stop_offset = r_out.stop_offset;

endmodule

// File: rtl/dtoi_checker.sv
// Port-level assertions for the decimal text to integer converter, bound to the top level.
module dtoi_port_checks
    import dtoi_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [63:0]          o_value,
    input logic                 o_parse_ok,
    input logic [STOP_BITS-1:0] o_stop_offset
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_parse_ok) && $stable(o_stop_offset))
        else $error("result word changed while stalled");

    // a good parse consumed at least one digit
    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parse_ok |-> o_stop_offset != '0)
        else $error("parse_ok with zero stop offset");

    // input backpressure only comes from a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind decimal_text_to_integer dtoi_port_checks u_dtoi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_value       (o_value),
    .o_parse_ok    (o_parse_ok),
    .o_stop_offset (o_stop_offset)
);

// File: bench/dtoi_checker.sv
// Checker for the decimal text to integer converter: watches both channels and compares results.
module dtoi_checker
    import dtoi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [63:0]          i_value,
    input  logic                 i_parse_ok,
    input  logic [STOP_BITS-1:0] i_stop_offset,
    output int                   o_fail_count,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    t_phase                 phase;
    logic [1:0]             fmt;
    logic [63:0]            acc;
    logic                   minus_seen;
    logic                   err_seen;
    logic [OFFSET_BITS-1:0] offset;

    t_result conversions_due[$];
    int      fail_count = 0;

    function automatic logic is_signed(input logic [1:0] f);
        return (f == FMT_S64) || (f == FMT_S32);
    endfunction

    // Largest magnitude the format accepts; a negative number may go one past the maximum.
    function automatic logic [63:0] magnitude_limit(input logic [1:0] f, input logic negative);
        case (f)
            FMT_U64: return '1;
            FMT_S64: return negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            FMT_U32: return 64'hFFFF_FFFF;
            default: return negative ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        endcase
    endfunction

    task automatic clear_parse();
        phase      = PH_SKIP;
        acc        = '0;
        minus_seen = 1'b0;
        err_seen   = 1'b0;
        offset     = '0;
    endtask

    task automatic bump_offset();
        if (offset != {OFFSET_BITS{1'b1}}) begin
            offset = offset + 1'b1;
        end
    endtask

    task automatic take_digit(input logic [7:0] c);
        logic [67:0] grown;
        if (c < CH_ZERO || c > CH_NINE) begin
            err_seen = 1'b1;
            phase    = PH_ERROR;
        end else begin
            grown = 68'(acc) * 68'd10 + 68'(c - CH_ZERO);
            if (grown > 68'(magnitude_limit(fmt, is_signed(fmt) && minus_seen))) begin
                err_seen = 1'b1;
                phase    = PH_ERROR;
            end else begin
                acc   = grown[63:0];
                phase = PH_DIGITS;
                bump_offset();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result     want;
        logic [63:0] wide_off;
        if (!i_rst_n) begin
            clear_parse();
            fmt = FMT_U64;
            conversions_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (conversions_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result word value %h ok %0b offset %0d",
                                 $realtime, i_value, i_parse_ok, i_stop_offset);
                    end
                end else begin
                    want = conversions_due.pop_front();
                    if (want.value !== i_value || want.parse_ok !== i_parse_ok ||
                        want.stop_offset !== i_stop_offset) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: result mismatch value exp %h got %h", $realtime,
                                     want.value, i_value);
                            $display("    parse_ok exp %0b got %0b, stop_offset exp %0d got %0d",
                                     want.parse_ok, i_parse_ok, want.stop_offset,
                                     i_stop_offset);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_char_byte == CH_NUL) begin
                    want.value = (is_signed(fmt) && minus_seen) ? -acc : acc;
                    if (fmt == FMT_U32) begin
                        want.value = {32'h0, want.value[31:0]};
                    end else if (fmt == FMT_S32) begin
                        want.value = {{32{want.value[31]}}, want.value[31:0]};
                    end
                    want.parse_ok = (phase == PH_DIGITS) && !err_seen;
                    wide_off = 64'(offset);
                    want.stop_offset = (wide_off > 64'(2 ** STOP_BITS - 1)) ?
                                       '1 : wide_off[STOP_BITS-1:0];
                    conversions_due.push_back(want);
                    clear_parse();
                end else begin
                    case (phase)
                        PH_SKIP: begin
                            if (i_char_byte <= CH_SPACE) begin
                                bump_offset();
                            end else if (i_char_byte == CH_MINUS && is_signed(fmt)) begin
                                minus_seen = 1'b1;
                                phase      = PH_FIRST;
                                bump_offset();
                            end else begin
                                take_digit(i_char_byte);
                            end
                        end
                        PH_FIRST, PH_DIGITS: begin
                            take_digit(i_char_byte);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            if (i_cfg_wr_en) begin
                fmt = i_cfg_wr_data;
            end
        end
        o_outstanding <= conversions_due.size();
        o_fail_count  <= fail_count;
    end

endmodule

// File: bench/tb_top.sv
// Testbench top for the decimal text to integer converter: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dtoi_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_WORDS = 1550;
    localparam int PHASES = 8;

    // Ways to bend a limit value into a digit string.
    localparam int BOUND_EXACT  = 0;
    localparam int BOUND_ABOVE  = 1;
    localparam int BOUND_BELOW  = 2;
    localparam int BOUND_LONGER = 3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           char_byte = '0;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_wr_data = FMT_U64;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [63:0]          value;
    logic                 parse_ok;
    logic [STOP_BITS-1:0] stop_offset;
    int                   fail_count;
    int                   outstanding;

    logic       sender_idles = 1'b1;
    logic       receiver_idles = 1'b1;
    logic [1:0] cur_fmt = FMT_U64;
    logic [7:0] text_bytes[$];
    int         counted = 0;
    int         cycle_count = 0;

    always #5 clk = ~clk;

    decimal_text_to_integer u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_char_byte   (char_byte),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_value       (value),
        .o_parse_ok    (parse_ok),
        .o_stop_offset (stop_offset)
    );

    dtoi_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_char_byte   (char_byte),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_value       (value),
        .i_parse_ok    (parse_ok),
        .i_stop_offset (stop_offset),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(negedge clk) begin
        out_stall <= receiver_idles && ($urandom_range(0, 99) < 27);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic put(input logic [7:0] b, input logic counts);
        text_bytes.push_back(b);
        if (counts) begin
            counted++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_byte(input logic [7:0] b);
        while (sender_idles && $urandom_range(0, 99) < 27) begin
            in_valid  <= 1'b0;
            char_byte <= 8'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i]) begin
            send_byte(text_bytes[i]);
        end
        text_bytes.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
    endtask

    // Hold until idle, let the last byte clear the pipeline, then write the format.
    task automatic set_format(input logic [1:0] f);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_fmt = f;
    endtask

    task automatic push_number(input logic [63:0] mag, input int variant);
        logic [7:0]  digits[$];
        logic [63:0] rest;
        rest = mag;
        do begin
            digits.push_front(CH_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        case (variant)
            BOUND_ABOVE: digits[digits.size() - 1] = digits[digits.size() - 1] + 8'd1;
            BOUND_BELOW: digits[digits.size() - 1] = digits[digits.size() - 1] - 8'd1;
            BOUND_LONGER: digits.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            default: begin
            end
        endcase
        foreach (digits[i]) begin
            put(digits[i], 1'b1);
        end
    endtask

    task automatic build_string();
        int          kind;
        int          pos;
        logic        minus;
        logic [63:0] mag;
        logic [7:0]  junk;
        kind = $urandom_range(0, 99);
        if (kind >= 95) begin
            // raw noise
            repeat ($urandom_range(0, 6)) put(8'($urandom_range(1, 255)), 1'b1);
        end else begin
            repeat ($urandom_range(0, 3)) put(8'($urandom_range(1, 32)), 1'b1);
            if (cur_fmt == FMT_S64 || cur_fmt == FMT_S32) begin
                minus = 1'($urandom_range(0, 1));
            end else begin
                minus = ($urandom_range(0, 9) == 0);
            end
            if (minus) begin
                put(CH_MINUS, 1'b1);
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 2)) put(CH_ZERO, 1'b1);
            end
            if (kind < 20) begin
                push_number(64'($urandom_range(0, 99999)), BOUND_EXACT);
            end else if (kind < 45) begin
                mag = {$urandom, $urandom};
                push_number(mag >> $urandom_range(0, 63), BOUND_EXACT);
            end else begin
                // land on, just under or just past the format's limit
                case (cur_fmt)
                    FMT_U64: mag = '1;
                    FMT_S64: mag = minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    FMT_U32: mag = 64'hFFFF_FFFF;
                    default: mag = minus ? 64'h8000_0000 : 64'h7FFF_FFFF;
                endcase
                push_number(mag, $urandom_range(BOUND_EXACT, BOUND_LONGER));
            end
            if (kind >= 80) begin
                // break the string with a non-digit, then trail a few ignored bytes
                do junk = 8'($urandom_range(1, 255)); while (junk >= CH_ZERO && junk <= CH_NINE);
                pos = $urandom_range(0, text_bytes.size());
                text_bytes.insert(pos, junk);
                counted++;
                repeat ($urandom_range(0, 3)) put(8'($urandom_range(1, 255)), 1'b0);
            end
        end
        put(CH_NUL, 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // format after reset: empty, blanks, high byte, stray letter, minus in unsigned
        put(CH_NUL, 1'b1);
        put(8'h01, 1'b1);
        put(CH_SPACE, 1'b1);
        put(CH_ZERO + 8'd7, 1'b1);
        put(CH_NUL, 1'b1);
        put(8'hFF, 1'b1);
        put(CH_NUL, 1'b1);
        put(CH_ZERO + 8'd5, 1'b1);
        put(8'h78, 1'b1);
        put(CH_NINE, 1'b1);
        put(CH_NUL, 1'b1);
        put(CH_MINUS, 1'b1);
        put(CH_ZERO + 8'd3, 1'b1);
        put(CH_NUL, 1'b1);
        send_text();

        // most negative values wrap to the format minimum
        set_format(FMT_S32);
        put(CH_MINUS, 1'b1);
        push_number(64'h8000_0000, BOUND_EXACT);
        put(CH_NUL, 1'b1);
        put(CH_MINUS, 1'b1);
        put(CH_NUL, 1'b1);
        send_text();
        set_format(FMT_S64);
        put(CH_MINUS, 1'b1);
        push_number(64'h8000_0000_0000_0000, BOUND_EXACT);
        put(CH_NUL, 1'b1);
        put(CH_MINUS, 1'b1);
        send_text();

        // switch to unsigned after the minus sign has been taken
        set_format(FMT_U64);
        put(CH_ZERO + 8'd3, 1'b1);
        put(CH_NUL, 1'b1);
        send_text();

        counted = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_format(FMT_S32);
                1: set_format(FMT_U64);
                2: set_format(FMT_S64);
                3: set_format(FMT_U32);
                default: set_format(2'($urandom_range(0, 3)));
            endcase
            sender_idles   = (p != 4);
            receiver_idles = (p != 4);
            while (counted < (p + 1) * RANDOM_WORDS / PHASES) begin
                build_string();
                send_text();
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
